// File: src/tactile_baseline_touch_detector_core_assert.svh
// Assertion macros shared by the tactile touch detector modules.
`ifndef TACTILE_BASELINE_TOUCH_DETECTOR_CORE_ASSERT_SVH
`define TACTILE_BASELINE_TOUCH_DETECTOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define TBTD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TBTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TBTD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TBTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/tbtd_pkg.sv
// Types, widths and constants of the tactile touch detector.
package tbtd_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int FRAC_W      = 8;
    localparam int BASE_W      = 16;
    localparam int FRAMES_W    = 10;
    localparam int FTHR_W      = 12;
    localparam int PTHR_W      = 14;
    localparam int PRESS_W     = 23;
    localparam int DEV_W       = BASE_W + 1;
    localparam int QUOT_W      = 16;
    localparam int DIVISOR_W   = 10;
    localparam int NUMER_W     = QUOT_W + DIVISOR_W;
    localparam int NUM_GROUPS  = 16;
    localparam int GROUP_W     = 4;
    localparam int NUM_REGIONS = 6;
    localparam int REGION_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int MASK_W      = NUM_REGIONS;

    // Exponential average: new = (19*old + sample + 10) / 20.
    localparam logic [DIVISOR_W-1:0] EMA_MULT  = 10'd19;
    localparam logic [DIVISOR_W-1:0] EMA_DIV   = 10'd20;
    localparam logic [DIVISOR_W-1:0] EMA_ROUND = 10'd10;

    localparam logic [FRAMES_W-1:0] CALIB_FRAMES_RST = 10'd100;
    localparam logic [FTHR_W-1:0]   FINGER_THR_RST   = 12'd50;
    localparam logic [PTHR_W-1:0]   PALM_THR_RST     = 14'd20;

    localparam logic signed [PRESS_W-1:0] PRESS_MAX = 23'sh3FFFFF;
    localparam logic signed [PRESS_W-1:0] PRESS_MIN = 23'sh400000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CALIB_FRAMES = 2'd0,
        CFG_FINGER_THR   = 2'd1,
        CFG_PALM_THR     = 2'd2
    } t_cfg_idx;

    typedef enum logic [REGION_W-1:0] {
        RG_THUMB  = 3'd0,
        RG_INDEX  = 3'd1,
        RG_MIDDLE = 3'd2,
        RG_RING   = 3'd3,
        RG_LITTLE = 3'd4,
        RG_PALM   = 3'd5,
        RG_NONE   = 3'd6
    } t_region;

    typedef enum logic [2:0] {
        ST_CLR  = 3'd0,
        ST_IDLE = 3'd1,
        ST_RD   = 3'd2,
        ST_LD   = 3'd3,
        ST_DIV  = 3'd4,
        ST_FIN  = 3'd5
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [NUMER_W-1:0]   numer;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    // Taxel groups arrive as index, middle, ring, little, thumb, three empty,
    // four palm and four empty groups.
    function automatic t_region region_of(input logic [GROUP_W-1:0] grp);
        t_region r;
        case (grp)
            4'd0:    r = RG_INDEX;
            4'd1:    r = RG_MIDDLE;
            4'd2:    r = RG_RING;
            4'd3:    r = RG_LITTLE;
            4'd4:    r = RG_THUMB;
            4'd8:    r = RG_PALM;
            4'd9:    r = RG_PALM;
            4'd10:   r = RG_PALM;
            4'd11:   r = RG_PALM;
            default: r = RG_NONE;
        endcase
        return r;
    endfunction

endpackage

// File: src/tbtd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tbtd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/tbtd_div.sv
// Restoring divider, one quotient bit per cycle, for baseline averaging.
`include "tactile_baseline_touch_detector_core_assert.svh"

module tbtd_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tbtd_pkg::t_div_req                 i_req,
    output logic                               o_done,
    output logic [tbtd_pkg::QUOT_W-1:0]        o_quot
);

    localparam int CNT_W = $clog2(tbtd_pkg::QUOT_W);

    logic                              r_busy;
    logic                              r_done;
    logic [CNT_W-1:0]                  r_cnt;
    logic [tbtd_pkg::DIVISOR_W-1:0]    r_rem;
    logic [tbtd_pkg::DIVISOR_W-1:0]    r_div;
    logic [tbtd_pkg::QUOT_W-1:0]       r_shift;

    logic [tbtd_pkg::DIVISOR_W:0]      w_trial;
    logic [tbtd_pkg::DIVISOR_W:0]      w_diff;
    logic                              w_ge;

    // The quotient is known to fit 16 bits, so the top numerator bits start
    // below the divisor and the remainder never needs more than its width.
    assign w_trial = {r_rem, r_shift[tbtd_pkg::QUOT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(tbtd_pkg::QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem   <= i_req.numer[tbtd_pkg::NUMER_W-1:tbtd_pkg::QUOT_W];
            r_shift <= i_req.numer[tbtd_pkg::QUOT_W-1:0];
            r_div   <= i_req.divisor;
        end else if (r_busy) begin
            r_rem   <= w_ge ? w_diff[tbtd_pkg::DIVISOR_W-1:0]
                            : w_trial[tbtd_pkg::DIVISOR_W-1:0];
            r_shift <= {r_shift[tbtd_pkg::QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_shift;

    `TBTD_ASSERT_IMPL(a_div_no_restart, i_clk, i_rst_n, i_req.start, !r_busy, "divider restarted while busy")

endmodule

// File: src/tactile_baseline_touch_detector_core.sv
// Top level of the tactile touch detector with per-taxel baseline tracking.
// Takes one taxel sample per word, GROUP_SIZE*16 taxels to a frame, and
// returns one result word per frame on the word carrying tlast. Baselines
// live in one RAM of GROUP_SIZE*16 entries of 8.8 fixed point, read,
// updated and written back for each sample. A sample within the frame
// passes through a RAM read, a multiply, the bit-serial divider that forms
// both the calibration mean and the 0.95/0.05 average, a write-back and a
// finishing state before the next can be accepted. A sample beyond the
// frame length goes straight to the finishing state. After reset a clearing
// pass over all GROUP_SIZE*16 entries zeroes the baselines, during which no
// word is accepted; configuration writes are taken at any time. A frame
// result waits in an output register, so the next frame's samples are taken
// while it is held; the block only stalls at the end of a frame if the
// previous result has still not been taken.
`include "tactile_baseline_touch_detector_core_assert.svh"

module tactile_baseline_touch_detector_core #(
    parameter int GROUP_SIZE = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [tbtd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tbtd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] sample
    input  logic                              s_axis_tlast,  // last_of_frame
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [22:0] thumb_press, [45:23] index_press, [68:46] middle_press,
    // [91:69] ring_press, [114:92] little_press, [137:115] palm_press,
    // [143:138] touch_mask
    output logic [143:0]                      m_axis_tdata,
    output logic [1:0]                        m_axis_tuser   // [0] calibrating, [1] frame_error
);

    localparam int TOTAL  = GROUP_SIZE * tbtd_pkg::NUM_GROUPS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int POS_W  = $clog2(TOTAL + 1);
    localparam int IN_W   = $clog2(GROUP_SIZE);
    localparam int PW     = tbtd_pkg::PRESS_W;
    localparam int NR     = tbtd_pkg::NUM_REGIONS;

    tbtd_pkg::t_state                   r_state;
    tbtd_pkg::t_state                   n_state;

    logic [tbtd_pkg::FRAMES_W-1:0]      r_calib_frames;
    logic [tbtd_pkg::FTHR_W-1:0]        r_finger_thr;
    logic [tbtd_pkg::PTHR_W-1:0]        r_palm_thr;

    logic [POS_W-1:0]                   r_pos;
    logic [tbtd_pkg::GROUP_W-1:0]       r_grp;
    logic [IN_W-1:0]                    r_in_grp;
    logic [tbtd_pkg::FRAMES_W-1:0]      r_frames;
    logic                               r_len_bad;
    logic signed [PW-1:0]               r_sum [NR];

    logic [tbtd_pkg::SAMPLE_W-1:0]      r_sample;
    logic                               r_last;
    logic [tbtd_pkg::NUMER_W-1:0]       r_prod;
    logic [tbtd_pkg::DIVISOR_W-1:0]     r_divisor;
    logic [tbtd_pkg::DIVISOR_W-1:0]     r_round;

    logic                               r_out_valid;
    logic signed [PW-1:0]               r_out_press [NR];
    logic [tbtd_pkg::MASK_W-1:0]        r_out_mask;
    logic                               r_out_calib;
    logic                               r_out_err;

    logic                               w_in_acc;
    logic                               w_pos_ok;
    logic                               w_calib;
    logic [tbtd_pkg::FRAMES_W-1:0]      w_n;
    logic [tbtd_pkg::DIVISOR_W-1:0]     w_mult;
    logic                               w_out_busy;
    logic                               w_frame_bad;
    logic                               w_fin_load;
    logic                               w_clr_end;

    logic                               w_mem_we;
    logic                               w_mem_re;
    logic [tbtd_pkg::BASE_W-1:0]        w_mem_wdata;
    logic [tbtd_pkg::BASE_W-1:0]        w_rdata;
    tbtd_pkg::t_div_req                 w_div_req;
    logic                               w_div_done;
    logic [tbtd_pkg::QUOT_W-1:0]        w_quot;

    tbtd_pkg::t_region                  w_region;
    logic signed [tbtd_pkg::DEV_W-1:0]  w_dev;
    logic signed [PW:0]                 w_acc;
    logic signed [PW-1:0]               w_acc_sat;

    logic signed [PW-1:0]               w_press [NR];
    logic [tbtd_pkg::MASK_W-1:0]        w_mask;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_pos_ok    = (r_pos < POS_W'(TOTAL));
    assign w_calib     = (r_frames < r_calib_frames);
    assign w_n         = r_frames + tbtd_pkg::FRAMES_W'(1);
    assign w_mult      = w_calib ? r_frames : tbtd_pkg::EMA_MULT;
    assign w_out_busy  = r_out_valid && !m_axis_tready;
    assign w_frame_bad = r_len_bad || (r_pos != POS_W'(TOTAL));
    assign w_clr_end   = (r_pos == POS_W'(TOTAL - 1));

    // ---------------------------------------------------------------- FSM
    always_comb begin
        n_state = r_state;
        case (r_state)
            tbtd_pkg::ST_CLR: begin
                if (w_clr_end) begin
                    n_state = tbtd_pkg::ST_IDLE;
                end
            end
            tbtd_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_pos_ok ? tbtd_pkg::ST_RD : tbtd_pkg::ST_FIN;
                end
            end
            tbtd_pkg::ST_RD:  n_state = tbtd_pkg::ST_LD;
            tbtd_pkg::ST_LD:  n_state = tbtd_pkg::ST_DIV;
            tbtd_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = tbtd_pkg::ST_FIN;
                end
            end
            tbtd_pkg::ST_FIN: begin
                if (!r_last || !w_out_busy) begin
                    n_state = tbtd_pkg::ST_IDLE;
                end
            end
            default: n_state = tbtd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready     = 1'b0;
        w_mem_we          = 1'b0;
        w_mem_re          = 1'b0;
        w_mem_wdata       = w_quot;
        w_div_req.start   = 1'b0;
        w_fin_load        = 1'b0;
        case (r_state)
            tbtd_pkg::ST_CLR: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = '0;
            end
            tbtd_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_mem_re      = s_axis_tvalid && w_pos_ok;
            end
            tbtd_pkg::ST_LD: begin
                w_div_req.start = 1'b1;
            end
            tbtd_pkg::ST_DIV: begin
                w_mem_we = w_div_done;
            end
            tbtd_pkg::ST_FIN: begin
                w_fin_load = r_last && !w_out_busy;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign w_div_req.numer = r_prod
                           + tbtd_pkg::NUMER_W'({r_sample, {tbtd_pkg::FRAC_W{1'b0}}})
                           + tbtd_pkg::NUMER_W'(r_round);
    assign w_div_req.divisor = r_divisor;

    // ------------------------------------------------------------ storage
    tbtd_ram #(
        .WIDTH (tbtd_pkg::BASE_W),
        .DEPTH (TOTAL)
    ) u_baseline_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_pos[ADDR_W-1:0]),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (r_pos[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    tbtd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ------------------------------------------------ region accumulation
    assign w_region = tbtd_pkg::region_of(r_grp);
    assign w_dev    = $signed({1'b0, r_sample, {tbtd_pkg::FRAC_W{1'b0}}})
                    - $signed({1'b0, w_rdata});

    always_comb begin
        w_acc = (PW + 1)'(r_sum[w_region]) + (PW + 1)'(w_dev);
        if (w_acc[PW] != w_acc[PW-1]) begin
            w_acc_sat = w_acc[PW] ? tbtd_pkg::PRESS_MIN : tbtd_pkg::PRESS_MAX;
        end else begin
            w_acc_sat = w_acc[PW-1:0];
        end
    end

    // Negation of the most negative sum is the only case that saturates.
    always_comb begin : press_calc
        logic signed [PW-1:0] thr;
        for (int i = 0; i < NR; i++) begin
            if (r_sum[i] == tbtd_pkg::PRESS_MIN) begin
                w_press[i] = tbtd_pkg::PRESS_MAX;
            end else begin
                w_press[i] = -r_sum[i];
            end
            if (i == int'(tbtd_pkg::RG_PALM)) begin
                thr = $signed(PW'({r_palm_thr, {tbtd_pkg::FRAC_W{1'b0}}}));
            end else begin
                thr = $signed(PW'({r_finger_thr, {tbtd_pkg::FRAC_W{1'b0}}}));
            end
            w_mask[i] = (w_press[i] > thr);
        end
    end

    // ------------------------------------------------------ control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tbtd_pkg::ST_CLR;
            r_calib_frames <= tbtd_pkg::CALIB_FRAMES_RST;
            r_finger_thr   <= tbtd_pkg::FINGER_THR_RST;
            r_palm_thr     <= tbtd_pkg::PALM_THR_RST;
            r_pos          <= '0;
            r_grp          <= '0;
            r_in_grp       <= '0;
            r_frames       <= '0;
            r_len_bad      <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < NR; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == tbtd_pkg::CFG_CALIB_FRAMES) begin
                    r_calib_frames <= i_cfg_data[tbtd_pkg::FRAMES_W-1:0];
                end else if (i_cfg_idx == tbtd_pkg::CFG_FINGER_THR) begin
                    r_finger_thr <= i_cfg_data[tbtd_pkg::FTHR_W-1:0];
                end else if (i_cfg_idx == tbtd_pkg::CFG_PALM_THR) begin
                    r_palm_thr <= i_cfg_data[tbtd_pkg::PTHR_W-1:0];
                end
            end

            if (r_state == tbtd_pkg::ST_CLR) begin
                r_pos <= w_clr_end ? '0 : r_pos + POS_W'(1);
            end

            if (w_in_acc && !w_pos_ok) begin
                r_len_bad <= 1'b1;
            end

            if (r_state == tbtd_pkg::ST_RD && !w_calib
                    && w_region != tbtd_pkg::RG_NONE) begin
                r_sum[w_region] <= w_acc_sat;
            end

            if (r_state == tbtd_pkg::ST_DIV && w_div_done) begin
                r_pos <= r_pos + POS_W'(1);
                if (r_in_grp == IN_W'(GROUP_SIZE - 1)) begin
                    r_in_grp <= '0;
                    r_grp    <= r_grp + tbtd_pkg::GROUP_W'(1);
                end else begin
                    r_in_grp <= r_in_grp + IN_W'(1);
                end
            end

            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_fin_load) begin
                r_out_valid <= 1'b1;
                r_pos       <= '0;
                r_grp       <= '0;
                r_in_grp    <= '0;
                r_len_bad   <= 1'b0;
                if (w_calib && !w_frame_bad) begin
                    r_frames <= r_frames + tbtd_pkg::FRAMES_W'(1);
                end
                for (int i = 0; i < NR; i++) begin
                    r_sum[i] <= '0;
                end
            end
        end
    end

    // ------------------------------------------------------------ payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= s_axis_tdata[tbtd_pkg::SAMPLE_W-1:0];
            r_last   <= s_axis_tlast;
        end
        if (r_state == tbtd_pkg::ST_RD) begin
            r_prod    <= tbtd_pkg::NUMER_W'(w_rdata) * tbtd_pkg::NUMER_W'(w_mult);
            r_divisor <= w_calib ? w_n : tbtd_pkg::EMA_DIV;
            r_round   <= w_calib ? (w_n >> 1) : tbtd_pkg::EMA_ROUND;
        end
        if (w_fin_load) begin
            r_out_calib <= w_calib;
            r_out_err   <= w_frame_bad;
            for (int i = 0; i < NR; i++) begin
                r_out_press[i] <= (w_frame_bad || w_calib) ? '0 : w_press[i];
            end
            r_out_mask <= (w_frame_bad || w_calib) ? '0 : w_mask;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_mask,
                            r_out_press[tbtd_pkg::RG_PALM],
                            r_out_press[tbtd_pkg::RG_LITTLE],
                            r_out_press[tbtd_pkg::RG_RING],
                            r_out_press[tbtd_pkg::RG_MIDDLE],
                            r_out_press[tbtd_pkg::RG_INDEX],
                            r_out_press[tbtd_pkg::RG_THUMB]};
    assign m_axis_tuser  = {r_out_err, r_out_calib};

    `TBTD_ASSERT_IMPL(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= POS_W'(TOTAL), "taxel position beyond frame length")
    `TBTD_ASSERT_IMPL(a_done_in_div, i_clk, i_rst_n, w_div_done, r_state == tbtd_pkg::ST_DIV, "divider result outside divide phase")
    `TBTD_ASSERT_IMPL(a_no_ram_clash, i_clk, i_rst_n, w_mem_we, !w_mem_re, "baseline read and write in the same cycle")
    `TBTD_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, w_fin_load, r_pos == '0 && !r_len_bad, "frame state not cleared after result")

endmodule
